FILE: design/assert_macros.svh
// Assertion helper macros for the sparse table range-minimum block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: design/strm_pkg.sv
// Shared types and constants for the sparse table range-minimum block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package strm_pkg;

  localparam int IDX_W    = 10;   // query index and output position width
  localparam int KEY_IN_W = 32;   // key port width
  localparam int LOG_W    = 4;    // floor log2 of a range length up to 2^IDX_W

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVELS_DEF       = 11;
  localparam int KEY_WIDTH_DEF    = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the key at the next position
    logic build_init;  // start the build at level 1
    logic next_level;  // advance to the next level
    logic elem_rd;     // read the two lower-level entries of the current element
    logic elem_wr;     // write the merged entry, step to the next element
    logic finish;      // mark the table as built
    logic query;       // read the two blocks of a query, check the range
    logic emit;        // register the query word onto the result ports
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic level_ok;    // current level exists and its span fits the count
    logic elem_ok;     // current element of the level fits the count
  } ctl_stat_t;

endpackage

FILE: design/strm_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module strm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: design/strm_ctrl.sv
// Sequencer for loads, table build and queries.
// Depends on strm_pkg for the command and status structs and op codes.
`timescale 1ns / 1ps

module strm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_op,
  input  logic                 in_last,
  input  strm_pkg::ctl_stat_t  stat,
  output strm_pkg::ctl_cmd_t   cmd,
  output logic                 busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_QOUT = 2'd1;  // query data back from RAM
  localparam logic [1:0] S_BCHK = 2'd2;  // build: check level / element, issue reads
  localparam logic [1:0] S_BWR  = 2'd3;  // build: write merged entry

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == strm_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
            if (in_last) begin
              cmd.build_init = 1'b1;
              state_nxt      = S_BCHK;
            end
          end else begin
            cmd.query = 1'b1;
            state_nxt = S_QOUT;
          end
        end
      end
      S_QOUT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_BCHK: begin
        priority if (!stat.level_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (stat.elem_ok) begin
          cmd.elem_rd = 1'b1;
          state_nxt   = S_BWR;
        end else begin
          cmd.next_level = 1'b1;
        end
      end
      S_BWR: begin
        cmd.elem_wr = 1'b1;
        state_nxt   = S_BCHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: design/strm_dp.sv
// Datapath: level table RAM, element count, build counters, query merge.
// Depends on strm_pkg and strm_ram.
`timescale 1ns / 1ps

module strm_dp #(
  parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
  parameter int LEVELS       = strm_pkg::LEVELS_DEF,
  parameter int KEY_WIDTH    = strm_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  strm_pkg::ctl_cmd_t            cmd,
  input  logic [strm_pkg::KEY_IN_W-1:0] in_key,
  input  logic [strm_pkg::IDX_W-1:0]    in_left_index,
  input  logic [strm_pkg::IDX_W-1:0]    in_right_index,
  output strm_pkg::ctl_stat_t           stat,
  output logic                          out_valid,
  output logic [strm_pkg::KEY_IN_W-1:0] out_min_key,
  output logic [strm_pkg::IDX_W-1:0]    out_min_position,
  output logic                          out_range_error
);

  localparam int IDX_W  = strm_pkg::IDX_W;
  localparam int KIN_W  = strm_pkg::KEY_IN_W;
  localparam int LOG_W  = strm_pkg::LOG_W;
  localparam int IW     = $clog2(MAX_ELEMENTS);        // position bits
  localparam int CW     = $clog2(MAX_ELEMENTS + 1);    // count bits
  localparam int LW     = $clog2(LEVELS);              // level bits
  localparam int AW     = LW + IW;
  localparam int DEPTH  = LEVELS * (1 << IW);
  localparam int EW     = KEY_WIDTH + IW;              // entry: {key, position}
  localparam int CMPW   = (CW > IDX_W) ? CW : IDX_W;

  function automatic logic [LOG_W-1:0] floor_log2(input logic [IDX_W:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i <= IDX_W; i++) begin
      if (v[i]) begin
        r = LOG_W'(i);
      end
    end
    return r;
  endfunction

  // Control state
  logic [CW-1:0] count_r, count_nxt;
  logic          ready_r, ready_nxt;
  logic [LW:0]   lvl_r, lvl_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW:0]   span_r, span_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload
  logic             err_r, err_nxt;
  logic [KIN_W-1:0] out_key_r, out_key_nxt;
  logic [IDX_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_err_r, out_err_nxt;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, rdata_a, rdata_b;

  strm_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Load path
  logic [KEY_WIDTH+KIN_W-1:0] key_in_ext;
  logic [KEY_WIDTH-1:0]       key_masked;
  logic [CW-1:0]              base_cnt;
  logic [IW-1:0]              base_idx;
  logic                       load_room;

  assign key_in_ext = {{KEY_WIDTH{1'b0}}, in_key};
  assign key_masked = key_in_ext[KEY_WIDTH-1:0];
  assign base_cnt   = ready_r ? '0 : count_r;   // load after a build starts over
  assign base_idx   = base_cnt[IW-1:0];
  assign load_room  = (base_cnt < CW'(MAX_ELEMENTS));

  // Build addressing
  logic [LW-1:0] lvl_lo, lvl_prev;
  logic [LW:0]   lvl_dec;
  logic [CW:0]   half, idx_b_w, idx_end;
  logic [IW-1:0] idx_b;

  assign lvl_lo   = lvl_r[LW-1:0];
  assign lvl_dec  = lvl_r - (LW+1)'(1);
  assign lvl_prev = lvl_dec[LW-1:0];
  assign half     = span_r >> 1;
  assign idx_b_w  = (CW+1)'(idx_r) + half;
  assign idx_b    = idx_b_w[IW-1:0];
  assign idx_end  = (CW+1)'(idx_r) + span_r;

  assign stat.level_ok = (lvl_r < (LW+1)'(LEVELS)) && (span_r <= {1'b0, count_r});
  assign stat.elem_ok  = (idx_end <= {1'b0, count_r});

  // Query addressing: two overlapping blocks of 2^j
  logic [IDX_W:0]      len_q, pow_j, rs_q;
  logic [LOG_W-1:0]    jq_raw;
  logic [LW-1:0]       jq_c;
  logic [IW+IDX_W-1:0] l_ext;
  logic [IW+IDX_W:0]   rs_ext;
  logic [IW-1:0]       l_idx, rs_idx;
  logic                q_err;

  assign len_q  = {1'b0, in_right_index} - {1'b0, in_left_index} + (IDX_W+1)'(1);
  assign jq_raw = floor_log2(len_q);
  assign jq_c   = (int'(jq_raw) >= LEVELS) ? LW'(LEVELS - 1) : LW'(jq_raw);
  assign pow_j  = (IDX_W+1)'(1) << jq_c;
  assign rs_q   = {1'b0, in_right_index} + (IDX_W+1)'(1) - pow_j;
  assign l_ext  = {{IW{1'b0}}, in_left_index};
  assign rs_ext = {{IW{1'b0}}, rs_q};
  assign l_idx  = l_ext[IW-1:0];
  assign rs_idx = rs_ext[IW-1:0];
  assign q_err  = !ready_r || (in_left_index > in_right_index) ||
                  (CMPW'(in_right_index) >= CMPW'(count_r));

  // Merge: left operand kept only when strictly smaller
  logic [KEY_WIDTH-1:0]       a_key, b_key, m_key;
  logic [IW-1:0]              a_pos, b_pos, m_pos;
  logic                       pick_a;
  logic [KEY_WIDTH+KIN_W-1:0] key_out_ext;
  logic [IW+IDX_W-1:0]        pos_out_ext;

  assign a_key       = rdata_a[EW-1:IW];
  assign a_pos       = rdata_a[IW-1:0];
  assign b_key       = rdata_b[EW-1:IW];
  assign b_pos       = rdata_b[IW-1:0];
  assign pick_a      = (a_key < b_key);
  assign m_key       = pick_a ? a_key : b_key;
  assign m_pos       = pick_a ? a_pos : b_pos;
  assign key_out_ext = {{KIN_W{1'b0}}, m_key};
  assign pos_out_ext = {{IDX_W{1'b0}}, m_pos};

  // RAM port muxing
  always_comb begin
    we    = (cmd.load && load_room) || cmd.elem_wr;
    waddr = cmd.load ? {LW'(0), base_idx} : {lvl_lo, idx_r};
    wdata = cmd.load ? {key_masked, base_idx} : {m_key, m_pos};
    if (cmd.query) begin
      raddr_a = {jq_c, l_idx};
      raddr_b = {jq_c, rs_idx};
    end else begin
      raddr_a = {lvl_prev, idx_r};
      raddr_b = {lvl_prev, idx_b};
    end
  end

  always_comb begin
    count_nxt     = count_r;
    ready_nxt     = ready_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    span_nxt      = span_r;
    err_nxt       = err_r;
    out_valid_nxt = cmd.emit;
    out_key_nxt   = out_key_r;
    out_pos_nxt   = out_pos_r;
    out_err_nxt   = out_err_r;
    if (cmd.load) begin
      ready_nxt = 1'b0;
      count_nxt = load_room ? (base_cnt + CW'(1)) : base_cnt;
    end
    if (cmd.build_init) begin
      lvl_nxt  = (LW+1)'(1);
      idx_nxt  = '0;
      span_nxt = (CW+1)'(2);
    end
    if (cmd.next_level) begin
      lvl_nxt  = lvl_r + (LW+1)'(1);
      idx_nxt  = '0;
      span_nxt = span_r << 1;
    end
    if (cmd.elem_wr) begin
      idx_nxt = idx_r + IW'(1);
    end
    if (cmd.finish) begin
      ready_nxt = 1'b1;
    end
    if (cmd.query) begin
      err_nxt = q_err;
    end
    if (cmd.emit) begin
      out_err_nxt = err_r;
      out_key_nxt = err_r ? '0 : key_out_ext[KIN_W-1:0];
      out_pos_nxt = err_r ? '0 : pos_out_ext[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ready_r     <= 1'b0;
      lvl_r       <= '0;
      idx_r       <= '0;
      span_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      lvl_r       <= lvl_nxt;
      idx_r       <= idx_nxt;
      span_r      <= span_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r     <= err_nxt;
    out_key_r <= out_key_nxt;
    out_pos_r <= out_pos_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_min_key      = out_key_r;
  assign out_min_position = out_pos_r;
  assign out_range_error  = out_err_r;

endmodule

FILE: design/sparse_table_range_min_top.sv
// Query: the accepted word is read from the level table RAM into registers, then the merged
// result is registered onto the ports and strobed on out_valid; busy holds off the next word meanwhile.
// Load: taken while idle, busy stays low. Load with last: busy through the build, which checks
// and writes each entry of each level in turn, then finishes.
// Reset (synchronous, rst_n low) clears the count and built flag; table contents stay.
// Results are strobes: the receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sparse_table_range_min_top #(
  parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
  parameter int LEVELS       = strm_pkg::LEVELS_DEF,
  parameter int KEY_WIDTH    = strm_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel: word taken when start && !busy
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [strm_pkg::KEY_IN_W-1:0] in_key,
  input  logic                          in_last,
  input  logic [strm_pkg::IDX_W-1:0]    in_left_index,
  input  logic [strm_pkg::IDX_W-1:0]    in_right_index,
  // result channel: one-cycle strobe per query
  output logic                          out_valid,
  output logic [strm_pkg::KEY_IN_W-1:0] out_min_key,
  output logic [strm_pkg::IDX_W-1:0]    out_min_position,
  output logic                          out_range_error
);

  // Controller and datapath talk only through these two structs.
  strm_pkg::ctl_cmd_t  cmd;
  strm_pkg::ctl_stat_t stat;
  logic                ctl_busy;
  logic                accept;

  // The controller only acts on start while idle, so gate it here.
  assign accept = start && !ctl_busy;
  assign busy   = ctl_busy;

  // Sequencer: idle / query readout / build check / build write.
  strm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .in_op   (in_op),
    .in_last (in_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (ctl_busy)
  );

  // Level table RAM addressed {level, index}; level 0 holds the loaded keys,
  // level j entry i the (key, position) minimum over i .. i + 2^j - 1.
  // Merges keep the left entry only on a strictly smaller key.
  strm_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .KEY_WIDTH    (KEY_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_key           (in_key),
    .in_left_index    (in_left_index),
    .in_right_index   (in_right_index),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_min_key      (out_min_key),
    .out_min_position (out_min_position),
    .out_range_error  (out_range_error)
  );

  // An accepted query is always answered with a result strobe.
  `ASSERT_CLK(a_query_answered, clk, rst_n, (accept && in_op == strm_pkg::OP_QUERY) |=> ##1 out_valid, "query not answered two cycles after accept")
  // A load never produces a result word.
  `ASSERT_CLK(a_load_silent, clk, rst_n, (accept && in_op == strm_pkg::OP_LOAD) |=> ##1 !out_valid, "result word after a load")
  // A query passes through the readout state, so strobes never come back to back.
  `ASSERT_CLK(a_strobe_single, clk, rst_n, out_valid |=> !out_valid, "result strobe held two cycles")
  // Error words carry zero key and position.
  `ASSERT_NEVER(a_error_zero, clk, rst_n, out_valid && out_range_error && (out_min_key != '0 || out_min_position != '0), "error word with nonzero payload")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the sparse table range-minimum block.
// Depends on strm_pkg and sparse_table_range_min_top; has its own minimum-table predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int KEY_IN_W = strm_pkg::KEY_IN_W;
  localparam int IDX_W    = strm_pkg::IDX_W;
  localparam int MAX_N    = strm_pkg::MAX_ELEMENTS_DEF;
  localparam int LEVELS_N = strm_pkg::LEVELS_DEF;
  localparam int KEY_W    = strm_pkg::KEY_WIDTH_DEF;
  localparam logic [KEY_IN_W-1:0] KEY_MASK = KEY_IN_W'((64'd1 << KEY_W) - 64'd1);

  // Cycle limit for the hard stop below; it sits well above a full build plus all traffic.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One (key, position) entry of a level.
  typedef struct packed {
    logic [KEY_IN_W-1:0] key;
    logic [IDX_W-1:0]    pos;
  } min_entry_t;

  // What one query word should return.
  typedef struct packed {
    logic [KEY_IN_W-1:0] key;
    logic [IDX_W-1:0]    pos;
    logic                err;
  } min_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // All block inputs are known from time zero.
  logic                start          = 1'b0;
  logic                in_op          = strm_pkg::OP_LOAD;
  logic [KEY_IN_W-1:0] in_key         = '0;
  logic                in_last        = 1'b0;
  logic [IDX_W-1:0]    in_left_index  = '0;
  logic [IDX_W-1:0]    in_right_index = '0;

  logic                busy;
  logic                out_valid;
  logic [KEY_IN_W-1:0] out_min_key;
  logic [IDX_W-1:0]    out_min_position;
  logic                out_range_error;

  // Predictor state: level j, entry i holds the minimum of positions i .. i + 2^j - 1.
  min_entry_t  minima_levels [LEVELS_N][MAX_N];
  int unsigned key_count   = 0;
  bit          table_built = 1'b0;

  min_result_t expected_minima[$];
  min_result_t oldest_minimum;

  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned words_sent      = 0;
  int unsigned sender_idle_pct = 0;

  sparse_table_range_min_top #(
    .MAX_ELEMENTS (MAX_N),
    .LEVELS       (LEVELS_N),
    .KEY_WIDTH    (KEY_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_key           (in_key),
    .in_last          (in_last),
    .in_left_index    (in_left_index),
    .in_right_index   (in_right_index),
    .out_valid        (out_valid),
    .out_min_key      (out_min_key),
    .out_min_position (out_min_position),
    .out_range_error  (out_range_error)
  );

  // 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs (stuck busy, lost strobe).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Ties go to the right-hand operand: left wins only on a strictly smaller key.
  function automatic min_entry_t take_min(input min_entry_t a, input min_entry_t b);
    return (a.key < b.key) ? a : b;
  endfunction

  // Fill levels 1 and up from level 0 over the current count.
  function automatic void build_minima();
    int unsigned lv, i, span;
    for (lv = 1; lv < LEVELS_N; lv++) begin
      span = 1 << lv;
      if (span > key_count) break;
      for (i = 0; i + span <= key_count; i++)
        minima_levels[lv][i] = take_min(minima_levels[lv-1][i],
                                        minima_levels[lv-1][i + (span >> 1)]);
    end
    table_built = 1'b1;
  endfunction

  // Update the predictor for one accepted word; queue the result of a query.
  function automatic void predict_minimum(input logic op, input logic [KEY_IN_W-1:0] key,
                                          input logic last, input logic [IDX_W-1:0] lo,
                                          input logic [IDX_W-1:0] hi);
    min_result_t res;
    min_entry_t  best;
    int unsigned len, lv, right_start;
    res = '0;
    if (op == strm_pkg::OP_LOAD) begin
      // a load after a build starts a fresh array
      if (table_built) begin
        table_built = 1'b0;
        key_count   = 0;
      end
      // a full array drops the key, but a last mark still builds
      if (key_count < MAX_N) begin
        minima_levels[0][key_count] = '{key: key & KEY_MASK, pos: IDX_W'(key_count)};
        key_count++;
      end
      if (last) build_minima();
      return;
    end
    if (!table_built || lo > hi || hi >= key_count) begin
      res.err = 1'b1;
    end else begin
      len = hi - lo + 1;
      lv  = 0;
      while (len > 1) begin
        len >>= 1;
        lv++;
      end
      if (lv >= LEVELS_N) lv = LEVELS_N - 1;
      right_start = hi + 1 - (1 << lv);
      best    = take_min(minima_levels[lv][lo], minima_levels[lv][right_start]);
      res.key = best.key;
      res.pos = best.pos;
    end
    expected_minima = {expected_minima, res};
  endfunction

  // Result checker: every strobe must match the oldest outstanding query.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_minima.size() == 0) begin
        $error("result strobe with no query outstanding");
        mismatch_count++;
      end else begin
        oldest_minimum = expected_minima.pop_front();
        if (out_min_key !== oldest_minimum.key) begin
          $error("min_key: expected %0h, actual %0h", oldest_minimum.key, out_min_key);
          mismatch_count++;
        end
        if (out_min_position !== oldest_minimum.pos) begin
          $error("min_position: expected %0d, actual %0d",
                 oldest_minimum.pos, out_min_position);
          mismatch_count++;
        end
        if (out_range_error !== oldest_minimum.err) begin
          $error("range_error: expected %0b, actual %0b",
                 oldest_minimum.err, out_range_error);
          mismatch_count++;
        end
      end
    end
  end

  // Drive one word at a falling edge, hold it until taken, then predict.
  // start stays high when the next word follows back to back.
  task automatic send_word(input logic op, input logic [KEY_IN_W-1:0] key,
                           input logic last, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_op          <= op;
    in_key         <= key;
    in_last        <= last;
    in_left_index  <= lo;
    in_right_index <= hi;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_minimum(op, key, last, lo, hi);
    words_sent++;
  endtask

  // Sender holds off until every outstanding query has returned.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_minima.size() != 0) @(negedge clk);
  endtask

  task automatic send_load(input logic [KEY_IN_W-1:0] key, input logic last);
    send_word(strm_pkg::OP_LOAD, key, last, IDX_W'($urandom()), IDX_W'($urandom()));
  endtask

  task automatic send_query(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
                            input logic last);
    send_word(strm_pkg::OP_QUERY, $urandom(), last, lo, hi);
  endtask

  // Key flavors: wide random, a tiny range (lots of ties), or the extremes.
  function automatic logic [KEY_IN_W-1:0] pick_key(input int unsigned flavor);
    case (flavor)
      0: return $urandom();
      1: return KEY_IN_W'($urandom_range(3));
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return KEY_IN_W'(1);
          default: return '1 - 1;
        endcase
      end
    endcase
  endfunction

  // Queries with nothing built yet, one of them with a stray last mark.
  task automatic test_reset_state();
    send_query(10'd0, 10'd0, 1'b0);
    send_query(10'd0, 10'd3, 1'b1);
  endtask

  // Short hand-picked sequence: extremes, ties, every error path, rebuilds.
  task automatic test_directed_cases();
    send_load('1, 1'b0);
    send_load('0, 1'b0);
    send_load(KEY_IN_W'(5), 1'b0);
    send_load(KEY_IN_W'(5), 1'b0);
    send_load('1, 1'b1);
    send_query(10'd0, 10'd0, 1'b0);     // single element, max key
    send_query(10'd0, 10'd4, 1'b0);     // whole array
    send_query(10'd2, 10'd3, 1'b0);     // equal keys: right position wins
    send_query(10'd3, 10'd4, 1'b0);
    send_query(10'd4, 10'd1, 1'b0);     // left past right
    send_query(10'd0, 10'd5, 1'b0);     // right at the count
    send_query(10'd1023, 10'd1023, 1'b0);
    send_query(10'd0, 10'd4, 1'b1);     // last on a query is ignored
    // load after a build restarts the array
    send_load(KEY_IN_W'(7), 1'b1);
    send_query(10'd0, 10'd0, 1'b0);
    send_query(10'd0, 10'd1, 1'b0);
    // load without last leaves the table unbuilt
    send_load(KEY_IN_W'(9), 1'b0);
    send_query(10'd0, 10'd0, 1'b0);
    send_load(KEY_IN_W'(3), 1'b1);
    send_query(10'd0, 10'd1, 1'b0);
    drain_results();
  endtask

  // Overfill the array: the extra keys are dropped and the last mark still
  // builds over all 1024 entries, exercising the top level.
  task automatic test_full_array();
    int unsigned i;
    logic [IDX_W-1:0] lo, hi;
    for (i = 0; i < MAX_N + 2; i++)
      send_load(pick_key($urandom_range(1)), i == MAX_N + 1);
    send_query(10'd0, 10'd1023, 1'b0);
    send_query(10'd1023, 10'd1023, 1'b0);
    send_query(10'd1, 10'd1023, 1'b0);
    send_query(10'd512, 10'd1023, 1'b0);
    send_query(10'd0, 10'd511, 1'b0);
    for (i = 0; i < 30; i++) begin
      lo = IDX_W'($urandom());
      hi = IDX_W'($urandom_range(MAX_N - 1, lo));
      send_query(lo, hi, 1'(i));
    end
    drain_results();
  endtask

  // One array followed by its queries; sometimes the last mark is missing.
  task automatic random_session();
    int unsigned n_keys, n_queries, pick, flavor, i;
    bit broken;
    logic [IDX_W-1:0] lo, hi;
    pick = $urandom_range(99);
    if (pick < 75)      n_keys = $urandom_range(1, 24);
    else if (pick < 95) n_keys = $urandom_range(25, 96);
    else                n_keys = $urandom_range(97, 256);
    flavor = $urandom_range(2);
    broken = ($urandom_range(99) < 8);
    for (i = 0; i < n_keys; i++)
      send_load(pick_key(flavor), (i == n_keys - 1) && !broken);
    n_queries = $urandom_range(4, 16);
    for (i = 0; i < n_queries; i++) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        lo = IDX_W'($urandom_range(n_keys - 1));
        hi = IDX_W'($urandom_range(n_keys - 1, lo));
      end else if (pick < 90) begin
        lo = IDX_W'($urandom_range(1023, 1));
        hi = IDX_W'($urandom_range(lo - 1));
      end else begin
        hi = IDX_W'($urandom_range(1023, n_keys));
        lo = IDX_W'($urandom_range(hi));
      end
      send_query(lo, hi, 1'($urandom_range(1)));
    end
  endtask

  // Three stretches of random sessions: light, heavy, then no sender gaps.
  task automatic test_random_traffic();
    int unsigned idle_steps[3] = '{6, 58, 0};
    int unsigned target;
    foreach (idle_steps[s]) begin
      sender_idle_pct = idle_steps[s];
      target = words_sent + 16;
      while (words_sent < target) random_session();
      drain_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 6;
    test_reset_state();
    test_directed_cases();
    test_full_array();
    test_random_traffic();

    drain_results();
    // a trailing build may still be running
    while (busy) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
